@@ rtl/core/u2g_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2g_pkg
// Shared types, codes and the GSM 03.38 default alphabet and extension table
// lookup for the UTF-8 to GSM 7-bit mapper.
// ----------------------------------------------------------------------------
package u2g_pkg;

    localparam logic [6:0] ESC_SEPTET = 7'h1B;

    typedef enum logic [1:0] {
        ST_MAPPED    = 2'd0,
        ST_UNMAPPED  = 2'd1,
        ST_INVALID   = 2'd2
    } t_status;

    typedef struct packed {
        logic [6:0] first_septet;
        logic [6:0] second_septet;
        logic [1:0] septet_count;
    } t_gsm_map;

    typedef struct packed {
        logic        valid;
        logic [15:0] code_point;
        logic [6:0]  first_septet;
        logic [6:0]  second_septet;
        logic [1:0]  septet_count;
        t_status     status;
    } t_dec_result;

    function automatic t_gsm_map map_gsm(input logic [15:0] cp);
        t_gsm_map   m;
        logic [7:0] b;
        logic [7:0] e;
        b = 8'h80;
        e = 8'h80;
        m = '0;
        case (cp) inside
            [16'h0020:16'h0023], [16'h0025:16'h003F],
            [16'h0041:16'h005A], [16'h0061:16'h007A]: b = {1'b0, cp[6:0]};
            16'h0040: b = 8'h00;  16'h00A3: b = 8'h01;
            16'h0024: b = 8'h02;  16'h00A5: b = 8'h03;
            16'h00E8: b = 8'h04;  16'h00E9: b = 8'h05;
            16'h00F9: b = 8'h06;  16'h00EC: b = 8'h07;
            16'h00F2: b = 8'h08;  16'h00C7: b = 8'h09;
            16'h000A: b = 8'h0A;  16'h00D8: b = 8'h0B;
            16'h00F8: b = 8'h0C;  16'h000D: b = 8'h0D;
            16'h00C5: b = 8'h0E;  16'h00E5: b = 8'h0F;
            16'h0394: b = 8'h10;  16'h005F: b = 8'h11;
            16'h03A6: b = 8'h12;  16'h0393: b = 8'h13;
            16'h039B: b = 8'h14;  16'h03A9: b = 8'h15;
            16'h03A0: b = 8'h16;  16'h03A8: b = 8'h17;
            16'h03A3: b = 8'h18;  16'h0398: b = 8'h19;
            16'h039E: b = 8'h1A;  16'h00C6: b = 8'h1C;
            16'h00E6: b = 8'h1D;  16'h00DF: b = 8'h1E;
            16'h00C9: b = 8'h1F;  16'h00A4: b = 8'h24;
            16'h00A1: b = 8'h40;  16'h00C4: b = 8'h5B;
            16'h00D6: b = 8'h5C;  16'h00D1: b = 8'h5D;
            16'h00DC: b = 8'h5E;  16'h00A7: b = 8'h5F;
            16'h00BF: b = 8'h60;  16'h00E4: b = 8'h7B;
            16'h00F6: b = 8'h7C;  16'h00F1: b = 8'h7D;
            16'h00FC: b = 8'h7E;  16'h00E0: b = 8'h7F;
            16'h000C: e = 8'h0A;  16'h005E: e = 8'h14;
            16'h007B: e = 8'h28;  16'h007D: e = 8'h29;
            16'h005C: e = 8'h2F;  16'h005B: e = 8'h3C;
            16'h007E: e = 8'h3D;  16'h005D: e = 8'h3E;
            16'h007C: e = 8'h40;  16'h20AC: e = 8'h65;
            default: ;
        endcase
        if (!b[7]) begin
            m.first_septet = b[6:0];
            m.septet_count = 2'd1;
        end else if (!e[7]) begin
            m.first_septet  = ESC_SEPTET;
            m.second_septet = e[6:0];
            m.septet_count  = 2'd2;
        end
        return m;
    endfunction

endpackage

@@ rtl/core/u2g_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2g_decoder
// Strict BMP UTF-8 decoder with pending-sequence state and GSM mapping of
// each completed code point.
// ----------------------------------------------------------------------------
module u2g_decoder (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_text_byte,
    output u2g_pkg::t_dec_result  o_result
);
    import u2g_pkg::*;

    logic [7:0]  r_lead_byte,     n_lead_byte;
    logic [1:0]  r_bytes_seen,    n_bytes_seen;
    logic [11:0] r_partial_point, n_partial_point;

    logic        cont, two, three;
    logic        emit_pt, emit_err;
    logic [15:0] point;
    t_gsm_map    gmap;

    always_comb begin
        cont  = (i_text_byte[7:6] == 2'b10);
        two   = (r_lead_byte >= 8'hC2) && (r_lead_byte <= 8'hDF);
        three = (r_lead_byte >= 8'hE0) && (r_lead_byte <= 8'hEF);

        emit_pt         = 1'b0;
        emit_err        = 1'b0;
        point           = '0;
        n_lead_byte     = r_lead_byte;
        n_bytes_seen    = r_bytes_seen;
        n_partial_point = r_partial_point;

        if (r_bytes_seen == 2'd1 && two) begin
            if (!cont) begin
                emit_err = 1'b1;
            end else begin
                emit_pt = 1'b1;
                point   = {5'd0, r_partial_point[4:0], i_text_byte[5:0]};
            end
        end else if (r_bytes_seen == 2'd1 && three) begin
            if (!cont
                || (r_lead_byte == 8'hE0 && i_text_byte < 8'hA0)
                || (r_lead_byte == 8'hED && i_text_byte >= 8'hA0)) begin
                emit_err = 1'b1;
            end else begin
                n_partial_point = {2'd0, r_partial_point[3:0], i_text_byte[5:0]};
                n_bytes_seen    = 2'd2;
            end
        end else if (r_bytes_seen == 2'd2 && three) begin
            if (!cont) begin
                emit_err = 1'b1;
            end else begin
                emit_pt = 1'b1;
                point   = {r_partial_point[9:0], i_text_byte[5:0]};
            end
        end else begin
            n_lead_byte     = '0;
            n_bytes_seen    = '0;
            n_partial_point = '0;
            if (!i_text_byte[7]) begin
                if (i_text_byte == 8'h00) begin
                    emit_err = 1'b1;
                end else begin
                    emit_pt = 1'b1;
                    point   = {8'd0, i_text_byte};
                end
            end else if (i_text_byte >= 8'hC2 && i_text_byte <= 8'hDF) begin
                n_lead_byte     = i_text_byte;
                n_partial_point = {7'd0, i_text_byte[4:0]};
                n_bytes_seen    = 2'd1;
            end else if (i_text_byte >= 8'hE0 && i_text_byte <= 8'hEF) begin
                n_lead_byte     = i_text_byte;
                n_partial_point = {8'd0, i_text_byte[3:0]};
                n_bytes_seen    = 2'd1;
            end else begin
                emit_err = 1'b1;
            end
        end

        if (emit_pt || emit_err) begin
            n_lead_byte     = '0;
            n_bytes_seen    = '0;
            n_partial_point = '0;
        end

        gmap = map_gsm(point);

        o_result.valid = emit_pt || emit_err;
        if (emit_err) begin
            o_result.code_point    = '0;
            o_result.first_septet  = '0;
            o_result.second_septet = '0;
            o_result.septet_count  = '0;
            o_result.status        = ST_INVALID;
        end else begin
            o_result.code_point    = point;
            o_result.first_septet  = gmap.first_septet;
            o_result.second_septet = gmap.second_septet;
            o_result.septet_count  = gmap.septet_count;
            o_result.status        = (gmap.septet_count == 2'd0) ? ST_UNMAPPED : ST_MAPPED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_byte     <= '0;
            r_bytes_seen    <= '0;
            r_partial_point <= '0;
        end else if (i_step) begin
            r_lead_byte     <= n_lead_byte;
            r_bytes_seen    <= n_bytes_seen;
            r_partial_point <= n_partial_point;
        end
    end

endmodule

@@ rtl/core/utf8_to_gsm7_mapper_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_gsm7_mapper_unit
// UTF-8 byte stream to GSM 03.38 septets, one result per completed code point
// or per invalid sequence.
//
//   channel  dir  handshake                 payload
//   input    in   i_in_valid / o_in_stall   i_text_byte
//   result   out  o_out_valid / i_out_stall o_code_point, o_first_septet,
//                                           o_second_septet, o_septet_count,
//                                           o_status
//
// one byte per cycle unless the result stalls; input register, single-pass
// decode and lookup, result register
// lead and middle bytes of a multibyte form yield no result
// synchronous active-low reset clears the pending sequence and both valids
// a stalled result holds the decode stage; an empty input register takes
// one more byte, then the input stalls
// ----------------------------------------------------------------------------
module utf8_to_gsm7_mapper_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_text_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_code_point,
    output logic [6:0]  o_first_septet,
    output logic [6:0]  o_second_septet,
    output logic [1:0]  o_septet_count,
    output logic [1:0]  o_status
);
    import u2g_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    logic [15:0] r_code_point;
    logic [6:0]  r_first_septet;
    logic [6:0]  r_second_septet;
    logic [1:0]  r_septet_count;
    t_status     r_status;

    logic        advance;
    logic        step;
    t_dec_result dec;

    assign advance    = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    u2g_decoder u_decoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_text_byte (r_in_byte),
        .o_result    (dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= step && dec.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_text_byte;
        end
        if (step && dec.valid) begin
            r_code_point    <= dec.code_point;
            r_first_septet  <= dec.first_septet;
            r_second_septet <= dec.second_septet;
            r_septet_count  <= dec.septet_count;
            r_status        <= dec.status;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_code_point    = r_code_point;
    assign o_first_septet  = r_first_septet;
    assign o_second_septet = r_second_septet;
    assign o_septet_count  = r_septet_count;
    assign o_status        = r_status;

    // invalid results carry no code point and no septets
    a_invalid_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_INVALID) |->
            (o_code_point == '0 && o_septet_count == 2'd0 && o_first_septet == '0))
        else $error("invalid result carries payload");

    // escaped pair always starts with the escape septet
    a_escape_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_septet_count == 2'd2) |->
            (o_first_septet == ESC_SEPTET && o_status == ST_MAPPED))
        else $error("escaped pair without escape septet");

    // status agrees with septet count
    a_status_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_septet_count == 2'd0) == (o_status != ST_MAPPED)))
        else $error("status and septet count disagree");

    // a held result is not overwritten by the decode stage
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_code_point)))
        else $error("stalled result changed");

endmodule
